### rtl/assert_macros.svh
// Assertion macros used by the checker file spq_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SPQ_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/spq_pkg.sv
// Package for the sorted priority queue: widths, codes and entry types.
// No dependencies.
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W     = 32;
  localparam int PRI_W     = 8;
  localparam int CNT_OUT_W = 7;
  localparam int STAT_W    = 2;
  localparam int IN_DW     = 40;
  localparam int OUT_DW    = 40;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } spq_op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } spq_status_t;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] pri;
  } spq_entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] pri;
  } spq_cmd_t;

  localparam spq_entry_t ENTRY_NONE = '{valid: 1'b0, value: '0, pri: '0};

endpackage

`default_nettype wire

### rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts towards the tail on
// insert and towards the head on remove. Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  spq_pkg::spq_cmd_t    cmd,
  input  spq_pkg::spq_entry_t  left_ent,
  input  wire                  left_keep,
  input  spq_pkg::spq_entry_t  right_ent,
  output spq_pkg::spq_entry_t  ent,
  output logic                 keep
);
  import spq_pkg::*;

  logic             valid_r, valid_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic [PRI_W-1:0] pri_r, pri_nxt;

  // entry stays put on insert: valid and priority not below the new one
  assign keep = valid_r && (pri_r >= cmd.pri);
  assign ent  = '{valid: valid_r, value: value_r, pri: pri_r};

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    pri_nxt   = pri_r;
    if (cmd.ins && !keep) begin
      if (left_keep) begin
        valid_nxt = 1'b1;
        value_nxt = cmd.value;
        pri_nxt   = cmd.pri;
      end else begin
        valid_nxt = left_ent.valid;
        value_nxt = left_ent.value;
        pri_nxt   = left_ent.pri;
      end
    end else if (cmd.rem) begin
      valid_nxt = right_ent.valid;
      value_nxt = right_ent.value;
      pri_nxt   = right_ent.pri;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    pri_r   <= pri_nxt;
  end

endmodule

`default_nettype wire

### rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: chain of spq_cell slots, fill
// count and registered result stage. Depends on spq_pkg and spq_cell.
`default_nettype none

// Sorted priority queue, DEPTH entries held in descending priority order.
//
// Input channel (in_*): one item per handshake. in_tuser is the opcode
// (insert or remove); in_tdata carries the value and its priority.
// Result channel (out_*): exactly one result item per input item, in order.
// out_tuser is the status, out_tdata the removed value, count and empty flag.
//
// Each slot of the chain compares its own priority with the incoming one and
// picks its next content from itself, the new entry or a neighbour, so all
// slots update together. One item is accepted every cycle while results are
// read; the result appears on out_* the cycle after acceptance.
// Throughput is set by the single output register: a new item is taken
// whenever that register is empty or being read in the same cycle.
//
// Insert into a full queue is dropped (status full); remove from an empty
// queue returns all ones (status empty). Equal priorities leave in arrival
// order. If the receiver stalls, the result is held and in_tready drops
// until it is taken. Reset (synchronous, active low) empties the queue and
// the output register; slot contents are not cleared, only their valid bits.
module sorted_priority_queue_top #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire [spq_pkg::IN_DW-1:0]   in_tdata,   // [31:0] item_value, [39:32] item_priority
  input  wire                        in_tuser,   // [0] opcode
  output logic                       out_tvalid,
  input  wire                        out_tready,
  output logic [spq_pkg::OUT_DW-1:0] out_tdata,  // [31:0] removed_value, [38:32] entry_count,
                                                 // [39] is_empty
  output logic [spq_pkg::STAT_W-1:0] out_tuser   // [1:0] status
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic             accept;
  logic             is_rem;
  logic             full, empty;
  logic [CW-1:0]    count_r, count_nxt;
  spq_cmd_t         cmd;
  spq_entry_t       ent  [DEPTH];
  logic             keep [DEPTH];

  logic              out_valid_r;
  logic [VAL_W-1:0]  res_value_r, res_value_nxt;
  spq_status_t       res_stat_r, res_stat_nxt;
  logic [CW-1:0]     res_count_r;
  logic              res_empty_r;
  logic [CW+CNT_OUT_W-1:0] count_ext;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_rem    = (in_tuser == OP_REMOVE);
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);

  assign cmd.ins   = accept && !is_rem && !full;
  assign cmd.rem   = accept && is_rem && !empty;
  assign cmd.value = in_tdata[VAL_W-1:0];
  assign cmd.pri   = in_tdata[VAL_W+PRI_W-1:VAL_W];

  // slot 0 is the head; it sees an always-keeping, empty left neighbour
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t l_ent, r_ent;
    logic       l_keep;
    if (i == 0) begin : g_head
      assign l_ent  = ENTRY_NONE;
      assign l_keep = 1'b1;
    end else begin : g_mid
      assign l_ent  = ent[i-1];
      assign l_keep = keep[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign r_ent = ENTRY_NONE;
    end else begin : g_body
      assign r_ent = ent[i+1];
    end
    spq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_ent  (l_ent),
      .left_keep (l_keep),
      .right_ent (r_ent),
      .ent       (ent[i]),
      .keep      (keep[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    res_value_nxt = '0;
    res_stat_nxt  = STAT_OK;
    if (is_rem) begin
      if (empty) begin
        res_value_nxt = '1;
        res_stat_nxt  = STAT_EMPTY;
      end else begin
        res_value_nxt = ent[0].value;
        count_nxt     = count_r - CW'(1);
      end
    end else begin
      if (full) begin
        res_stat_nxt = STAT_FULL;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_value_r <= res_value_nxt;
      res_stat_r  <= res_stat_nxt;
      res_count_r <= count_nxt;
      res_empty_r <= (count_nxt == '0);
    end
  end

  // count is zero-extended, then its low CNT_OUT_W bits are shown
  assign count_ext  = {{CNT_OUT_W{1'b0}}, res_count_r};
  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_stat_r;
  assign out_tdata  = {res_empty_r, count_ext[CNT_OUT_W-1:0], res_value_r};

endmodule

`default_nettype wire

### rtl/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module spq_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_tvalid,
  input wire                        in_tready,
  input wire                        out_tvalid,
  input wire                        out_tready,
  input wire [spq_pkg::OUT_DW-1:0]  out_tdata,
  input wire [spq_pkg::STAT_W-1:0]  out_tuser
);
  import spq_pkg::*;

  // every accepted item yields a result the next cycle
  `SPQ_ASSERT(a_result_follows, (in_tvalid && in_tready) |=> out_tvalid, "no result after item")

  // empty remove reports all ones, zero count and empty
  `SPQ_ASSERT(a_empty_rem, (out_tvalid && out_tuser == STAT_EMPTY) |-> (out_tdata == {1'b1, 7'd0, 32'hFFFF_FFFF}), "bad empty-remove result")

  // a full drop reports a zero value and a non-empty queue
  `SPQ_ASSERT(a_full_nonempty, (out_tvalid && out_tuser == STAT_FULL) |-> (!out_tdata[39] && out_tdata[31:0] == 32'd0), "bad full-drop result")

  // stalled result holds
  `SPQ_ASSERT(a_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "stalled result changed")

  // reset empties the output stage
  `SPQ_ASSERT_ALL(a_reset, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);

`default_nettype wire

### bench/sorted_priority_queue_top_test.sv
// Self-checking bench for sorted_priority_queue_top: drives insert and remove items,
// keeps its own sorted-array copy of the queue and checks every result item.
// Depends on spq_pkg and the RTL of sorted_priority_queue_top.
`default_nettype none

module sorted_priority_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int QUEUE_DEPTH = DEPTH_DEF;
  // Generous: a few thousand items, even at the heaviest stall, stay well within it.
  localparam int CYCLE_LIMIT = 400000;
  // Spare cycles run at the end, after the results are drained.
  localparam int TAIL_CYCLES = 8;

  // One result item as the block should present it.
  typedef struct {
    logic [VAL_W-1:0]     value;
    spq_status_t          status;
    logic [CNT_OUT_W-1:0] count;
    logic                 empty;
  } queue_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;   // [31:0] item_value, [39:32] item_priority
  logic                in_tuser;   // [0] opcode
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;  // [31:0] removed_value, [38:32] entry_count, [39] is_empty
  logic [STAT_W-1:0]   out_tuser;  // [1:0] status

  // Own copy of the queue: values and priorities, head at index 0.
  logic [VAL_W-1:0]    model_val [QUEUE_DEPTH];
  logic [PRI_W-1:0]    model_pri [QUEUE_DEPTH];
  int                  model_fill;

  queue_result_t       pending_results[$];
  int                  error_count;
  int                  cycle_count;
  int                  send_idle_pct;
  int                  recv_stall_pct;

  sorted_priority_queue_top #(
    .DEPTH (QUEUE_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Queue predictor. An insert goes behind every entry of equal or higher
  // priority, so ties leave in arrival order; a full queue drops the insert.
  // A remove pops the head; an empty queue gives all ones and status empty.
  // ---------------------------------------------------------------------------
  function automatic queue_result_t predict_queue_step(spq_op_t op, logic [VAL_W-1:0] val,
                                                       logic [PRI_W-1:0] pri);
    queue_result_t r;
    int pos;
    int k;
    r.value  = '0;
    r.status = STAT_OK;
    if (op == OP_INSERT) begin
      if (model_fill >= QUEUE_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        pos = model_fill;
        while (pos > 0 && model_pri[pos-1] < pri) begin
          model_val[pos] = model_val[pos-1];
          model_pri[pos] = model_pri[pos-1];
          pos--;
        end
        model_val[pos] = val;
        model_pri[pos] = pri;
        model_fill++;
      end
    end else if (model_fill == 0) begin
      r.value  = '1;
      r.status = STAT_EMPTY;
    end else begin
      r.value = model_val[0];
      for (k = 0; k + 1 < model_fill; k++) begin
        model_val[k] = model_val[k+1];
        model_pri[k] = model_pri[k+1];
      end
      model_fill--;
    end
    // Count port is 7 bits wide; the empty flag is exact.
    r.count = CNT_OUT_W'(model_fill);
    r.empty = (model_fill == 0);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    $display("%0t ns: %s mismatch: got %h, expected %h", $time, field, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and predictor hook. Both handshakes are sampled at the
  // rising edge, before the flops of the block update. The result side is
  // handled first, so a result can only ever match an item accepted earlier.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result item", out_tdata[VAL_W-1:0], '0);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[31:0] !== want.value)
            report_mismatch("removed_value", out_tdata[31:0], want.value);
          if (out_tuser !== want.status)
            report_mismatch("status", VAL_W'(out_tuser), VAL_W'(want.status));
          if (out_tdata[38:32] !== want.count)
            report_mismatch("entry_count", VAL_W'(out_tdata[38:32]), VAL_W'(want.count));
          if (out_tdata[39] !== want.empty)
            report_mismatch("is_empty", VAL_W'(out_tdata[39]), VAL_W'(want.empty));
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(predict_queue_step(spq_op_t'(in_tuser),
                                                     in_tdata[31:0], in_tdata[39:32]));
    end
  end

  // Receiver: random back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Valid stays high straight into the next item when there is no
  // idle cycle, so it is never dropped and raised within one step.
  // ---------------------------------------------------------------------------
  task automatic send_item(spq_op_t op, logic [VAL_W-1:0] val, logic [PRI_W-1:0] pri);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {pri, val};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Priority mix: full range, the two extremes, or a narrow band to force ties.
  function automatic logic [PRI_W-1:0] pick_priority();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 8'hFF : 8'h00;
      1:       return 8'(100 + $urandom_range(3));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_item(int insert_pct);
    if ($urandom_range(99) < insert_pct)
      send_item(OP_INSERT, $urandom, pick_priority());
    else
      send_item(OP_REMOVE, $urandom, 8'($urandom));  // fields ignored on remove
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty removes, value and priority extremes, ties in arrival order.
  task automatic test_directed_cases();
    send_item(OP_REMOVE, '1, '1);
    send_item(OP_REMOVE, '0, '0);
    send_item(OP_INSERT, 32'h7FFF_FFFF, 8'h00);
    send_item(OP_INSERT, 32'h8000_0000, 8'hFF);
    send_item(OP_INSERT, 32'h0000_0000, 8'h80);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 8'h80);
    send_item(OP_INSERT, 32'h0000_0005, 8'h80);
    send_item(OP_INSERT, 32'h5555_5555, 8'hFF);
    send_item(OP_INSERT, 32'hAAAA_AAAA, 8'h00);
    send_item(OP_INSERT, 32'h0000_0001, 8'h7F);
    repeat (9) send_item(OP_REMOVE, '1, '1);
    send_item(OP_REMOVE, '1, '1);
  endtask

  // Fill to the brim, overflow inserts are dropped, refill one slot, drain past empty.
  task automatic test_full_queue();
    repeat (QUEUE_DEPTH) send_item(OP_INSERT, $urandom, pick_priority());
    send_item(OP_INSERT, 32'h1234_5678, 8'hFF);
    send_item(OP_INSERT, 32'h8765_4321, 8'h00);
    send_item(OP_REMOVE, '0, '0);
    send_item(OP_INSERT, 32'hCAFE_0001, 8'hFF);
    send_item(OP_INSERT, 32'hCAFE_0002, 8'hFF);
    repeat (QUEUE_DEPTH + 2) send_item(OP_REMOVE, $urandom, 8'($urandom));
  endtask

  // Bursts that lean towards filling, draining or balance, so the queue
  // swings between empty and full many times.
  task automatic test_random_traffic(int n_items);
    int sent;
    int burst;
    int insert_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(2))
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      burst = $urandom_range(20, 120);
      repeat (burst) send_random_item(insert_pct);
      sent += burst;
    end
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic test_drain_pause();
    repeat (6) begin
      repeat ($urandom_range(3, 15)) send_random_item(60);
      wait_results_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = OP_INSERT;
    out_tready     = 1'b0;
    error_count    = 0;
    cycle_count    = 0;
    model_fill     = 0;
    send_idle_pct  = 7;
    recv_stall_pct = 71;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender mostly busy, receiver stalling heavily.
    test_directed_cases();
    test_random_traffic(600);

    // Sender idling heavily, receiver mostly ready.
    send_idle_pct  = 71;
    recv_stall_pct = 7;
    test_full_queue();
    test_random_traffic(600);

    // Back to back on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_drain_pause();
    test_random_traffic(600);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sorted_priority_queue_top.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
rtl/spq_checker.sv
bench/sorted_priority_queue_top_test.sv
